// File: hdl/sorted_priority_queue_core_assert.svh
// Assertion macros for the sorted priority queue RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted priority queue check failed");
// Check a property on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT(label, clk, rst, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: hdl/spq_pkg.sv
// Types, codes and constants of the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

   localparam int DATA_BITS     = 32;
   localparam int PRIO_BITS     = 16;
   localparam int COUNT_BITS    = 5;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      func_type                     func;
      logic [DATA_BITS-1:0]         item_data;
      logic signed [PRIO_BITS-1:0]  item_priority;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic [DATA_BITS-1:0]         out_data;
      logic signed [PRIO_BITS-1:0]  out_priority;
      logic [COUNT_BITS-1:0]        count;
   } rsp_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]         data;
      logic signed [PRIO_BITS-1:0]  prio;
   } entry_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic      insert;
      logic      remove;
      logic      clear;
      entry_type item;
   } ctrl_type;

endpackage

// File: hdl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus
// handshake, occupancy count and result register. Depends on spq_pkg,
// spq_cell and sorted_priority_queue_core_assert.svh.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid, req_ready, req_payload   | in
//   result  | rsp_valid, rsp_ready, rsp_payload   | out
//
// One transaction per clock while the result register is free or draining: every cell compares against the request in
// parallel and the whole chain shifts in the accepting cycle. The result
// appears in the output register on the following cycle.
// Synchronous active-high reset empties the chain (valid bits and count);
// stored entries are not cleared. While a result waits unaccepted, a new
// request is taken only in a cycle where rsp_ready is high.
`include "sorted_priority_queue_core_assert.svh"
module sorted_priority_queue_core #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_payload
);
   import spq_pkg::*;

   localparam int OccBits = $clog2(DEPTH + 1);

   entry_type          cell_entry [DEPTH];
   logic [DEPTH-1:0]   cell_valid;
   logic [DEPTH-1:0]   cell_keep;
   logic [DEPTH-1:0]   cell_match;
   ctrl_type           ctrl;

   logic               req_fire;
   logic               is_full;
   logic               is_empty;
   logic [OccBits-1:0] occ_ff, occ_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   // Take a new request whenever the result register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Chain is filled from the front, so its ends tell full and empty.
   assign is_full  = cell_valid[DEPTH-1];
   assign is_empty = !cell_valid[0];

   assign ctrl.insert    = req_fire && (req_payload.func == FUNC_INSERT) && !is_full;
   assign ctrl.remove    = req_fire && (req_payload.func == FUNC_REMOVE) && !is_empty;
   assign ctrl.clear     = req_fire && (req_payload.func == FUNC_CLEAR);
   assign ctrl.item.data = req_payload.item_data;
   assign ctrl.item.prio = req_payload.item_priority;

   // Build the chain; the front cell always sees a kept left neighbor so an
   // insert lands there when no entry ranks at or above it, the back cell pulls nothing.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_valid, left_keep, right_valid;

      if (i == 0) begin : g_front
         assign left_entry = ctrl.item;
         assign left_valid = 1'b1;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .keep        (cell_keep[i]),
         .match       (cell_match[i])
      );
   end

   // Advance the occupancy count alongside the chain.
   always_comb begin
      occ_in = occ_ff;
      priority if (ctrl.clear) begin
         occ_in = '0;
      end else if (ctrl.insert) begin
         occ_in = occ_ff + OccBits'(1);
      end else if (ctrl.remove) begin
         occ_in = occ_ff - OccBits'(1);
      end else begin
         occ_in = occ_ff;
      end
   end

   // Form the result of the request taken in this cycle.
   always_comb begin
      rsp_in.status       = STATUS_OK;
      rsp_in.out_data     = '0;
      rsp_in.out_priority = '0;
      rsp_in.count        = COUNT_BITS'(occ_in);
      unique case (req_payload.func)
         FUNC_INSERT: begin
            if (is_full) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         FUNC_REMOVE: begin
            if (is_empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.out_data     = cell_entry[0].data;
               rsp_in.out_priority = cell_entry[0].prio;
            end
         end
         FUNC_SEARCH: begin
            if (!(|cell_match)) begin
               rsp_in.status = STATUS_EMPTY;
            end
         end
         FUNC_CLEAR: begin
            rsp_in.status = STATUS_OK;
         end
         default: begin
            rsp_in.status = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Count must agree with the number of occupied cells.
   `SPQ_ASSERT(a_occ_matches_cells, clock, reset, ($countones(cell_valid) == int'(occ_ff)))
   // The front cell is occupied whenever the count is nonzero.
   `SPQ_ASSERT(a_valid_prefix, clock, reset, ((cell_valid[0] == 1'b1) || (occ_ff == '0)))
   // A full status comes only from a full chain.
   `SPQ_ASSERT(a_full_status, clock, reset, (rsp_valid_ff && (rsp_ff.status == STATUS_FULL) |-> (occ_ff == OccBits'(DEPTH))))
   // A successful remove shrinks the count by one.
   `SPQ_ASSERT(a_remove_count, clock, reset, (ctrl.remove |=> (occ_ff == $past(occ_ff) - OccBits'(1))))

endmodule

// File: hdl/spq_cell.sv
// One slot of the sorted shift chain: holds an entry and its valid bit.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue_core.
module spq_cell (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::ctrl_type  ctrl,
   input  spq_pkg::entry_type left_entry,
   input  logic              left_valid,
   input  logic              left_keep,
   input  spq_pkg::entry_type right_entry,
   input  logic              right_valid,
   output spq_pkg::entry_type entry,
   output logic              valid,
   output logic              keep,
   output logic              match
);
   import spq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // Entry stays in place on insert when it ranks at or above the new item.
   assign keep  = valid_ff && (entry_ff.prio >= ctrl.item.prio);
   assign match = valid_ff && (entry_ff.data == ctrl.item.data)
                  && (entry_ff.prio == ctrl.item.prio);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert && !keep) begin
         if (left_keep) begin
            entry_in = ctrl.item;
            valid_in = 1'b1;
         end else begin
            entry_in = left_entry;
            valid_in = left_valid;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else begin
         // Hold the slot.
         entry_in = entry_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
